[rtl/fsme_pkg.sv]
// Shared constants, codes and types of the flow shop makespan evaluator.
package fsme_pkg;

	localparam int JOBS     = 16;
	localparam int STAGES   = 4;
	localparam int MACHINES = 16;

	localparam int JOB_W  = (JOBS > 1) ? $clog2(JOBS) : 1;
	localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int MCH_W  = (MACHINES > 1) ? $clog2(MACHINES) : 1;
	localparam int PT_W   = 12;
	localparam int TIME_W = 20;
	localparam int MCNT_W = 5;
	localparam int SCNT_W = 3;

	localparam int TBL_DEPTH = JOBS * STAGES;
	localparam int MFT_DEPTH = STAGES * MACHINES;
	localparam int MFT_AW    = STG_W + MCH_W;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Item kinds carried on the input tuser bit
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCHED = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_STAGES = 3'd0,
		REG_MACH0  = 3'd1,
		REG_MACH1  = 3'd2,
		REG_MACH2  = 3'd3,
		REG_MACH3  = 3'd4
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOOKUP = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_WRITE  = 7'b0001000,
		ST_MREAD  = 7'b0010000,
		ST_MAX    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	// Clamped configuration seen by the sequencer
	typedef struct packed {
		logic [STG_W-1:0]             last_stage;
		logic [STAGES-1:0][MCH_W-1:0] last_mach;
	} cfg_t;

	// One input item
	typedef struct packed {
		logic            command;
		logic [3:0]      job;
		logic [1:0]      stage;
		logic [PT_W-1:0] time_value;
		logic            last;
	} item_t;

	// One result item
	typedef struct packed {
		logic [TIME_W-1:0] job_finish;
		logic              sequence_done;
		logic [TIME_W-1:0] makespan;
	} res_t;

endpackage

[rtl/fsme_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fsme_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 20
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/fsme_seq.sv]
// Scheduling sequencer: table lookups, machine scans and free-time updates.
module fsme_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  fsme_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  fsme_pkg::item_t item,
	output logic            res_valid,
	input  logic            res_ready,
	output fsme_pkg::res_t  res
);

	import fsme_pkg::*;

	state_t              state_q;
	logic [JOB_W-1:0]    job_q;
	logic                last_q;
	logic [STG_W-1:0]    st_q;
	logic [MCH_W-1:0]    rd_idx_q;
	logic [TIME_W-1:0]   best_val_q;
	logic [MCH_W-1:0]    best_idx_q;
	logic [TIME_W-1:0]   finish_q;
	logic [TIME_W-1:0]   mk_q;
	logic [MFT_DEPTH-1:0] valid_q;
	logic [MFT_AW-1:0]   mft_raddr_s1;

	logic                in_fire;
	logic [MCH_W-1:0]    lim;
	logic                stage_ok;

	logic                tbl_we;
	logic [JOB_W+STG_W-1:0] tbl_waddr;
	logic                tbl_re;
	logic [JOB_W+STG_W-1:0] tbl_raddr;
	logic [PT_W-1:0]     tbl_rdata;

	logic                mft_we;
	logic [MFT_AW-1:0]   mft_waddr;
	logic                mft_re;
	logic [MFT_AW-1:0]   mft_raddr;
	logic [TIME_W-1:0]   mft_rdata;
	logic [TIME_W-1:0]   cur;

	logic [TIME_W-1:0]   start;
	logic [TIME_W:0]     sum_w;
	logic [TIME_W-1:0]   new_time;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign lim       = cfg.last_mach[st_q];
	assign stage_ok  = (32'(item.stage) < STAGES);

	// Processing time table: written by write items, read once per stage
	assign tbl_we    = in_fire && (item.command == CMD_WRITE) && stage_ok;
	assign tbl_waddr = {JOB_W'(item.job), STG_W'(item.stage)};
	assign tbl_re    = (state_q == ST_LOOKUP);
	assign tbl_raddr = {job_q, st_q};

	fsme_ram #(
		.DEPTH(TBL_DEPTH),
		.WIDTH(PT_W)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(item.time_value),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	// Machine free-time reads: first entry of a row, then one entry a cycle
	always_comb begin
		mft_re    = 1'b0;
		mft_raddr = {st_q, MCH_W'(0)};
		if (state_q == ST_LOOKUP || state_q == ST_MREAD) begin
			mft_re = 1'b1;
		end else if ((state_q == ST_SCAN || state_q == ST_MAX) && rd_idx_q != lim) begin
			mft_re    = 1'b1;
			mft_raddr = {st_q, rd_idx_q + MCH_W'(1)};
		end
	end

	// Start and saturated finish of the job on the chosen machine
	assign start    = (best_val_q > finish_q) ? best_val_q : finish_q;
	assign sum_w    = {1'b0, start} + (TIME_W+1)'(tbl_rdata);
	assign new_time = sum_w[TIME_W] ? TIME_MAX : sum_w[TIME_W-1:0];

	assign mft_we    = (state_q == ST_WRITE);
	assign mft_waddr = {st_q, best_idx_q};

	fsme_ram #(
		.DEPTH(MFT_DEPTH),
		.WIDTH(TIME_W)
	) u_mft (
		.clk  (clk),
		.we   (mft_we),
		.waddr(mft_waddr),
		.wdata(new_time),
		.re   (mft_re),
		.raddr(mft_raddr),
		.rdata(mft_rdata)
	);

	// Hold the address of the read in flight to look up its valid bit
	always_ff @(posedge clk) begin
		if (mft_re) begin
			mft_raddr_s1 <= mft_raddr;
		end
	end

	// An entry never written since the last clear reads as zero
	assign cur = valid_q[mft_raddr_s1] ? mft_rdata : '0;

	// Result toward the output register
	assign res_valid         = (state_q == ST_DONE);
	assign res.job_finish    = finish_q;
	assign res.sequence_done = last_q;
	assign res.makespan      = mk_q;

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			st_q     <= '0;
			rd_idx_q <= '0;
			valid_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && item.command == CMD_SCHED) begin
						st_q    <= '0;
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					rd_idx_q <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (tbl_rdata == '0) begin
						// skipped stage: advance
						if (st_q == cfg.last_stage) begin
							state_q <= last_q ? ST_MREAD : ST_DONE;
						end else begin
							st_q    <= st_q + STG_W'(1);
							state_q <= ST_LOOKUP;
						end
					end else if (rd_idx_q == lim) begin
						state_q <= ST_WRITE;
					end else begin
						rd_idx_q <= rd_idx_q + MCH_W'(1);
					end
				end
				ST_WRITE: begin
					valid_q[mft_waddr] <= 1'b1;
					if (st_q == cfg.last_stage) begin
						state_q <= last_q ? ST_MREAD : ST_DONE;
					end else begin
						st_q    <= st_q + STG_W'(1);
						state_q <= ST_LOOKUP;
					end
				end
				ST_MREAD: begin
					rd_idx_q <= '0;
					state_q  <= ST_MAX;
				end
				ST_MAX: begin
					if (rd_idx_q == lim) begin
						// order closed: drop all machine times
						valid_q <= '0;
						state_q <= ST_DONE;
					end else begin
						rd_idx_q <= rd_idx_q + MCH_W'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Job payload: order, best machine, finish and makespan
	always_ff @(posedge clk) begin
		if (in_fire && item.command == CMD_SCHED) begin
			job_q    <= JOB_W'(item.job);
			last_q   <= item.last;
			finish_q <= '0;
			mk_q     <= '0;
		end
		if (state_q == ST_SCAN && (rd_idx_q == '0 || cur < best_val_q)) begin
			best_val_q <= cur;
			best_idx_q <= rd_idx_q;
		end
		if (state_q == ST_WRITE) begin
			finish_q <= new_time;
		end
		if (state_q == ST_MAX && cur > mk_q) begin
			mk_q <= cur;
		end
	end

`ifndef SYNTH
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && tbl_rdata != '0) |-> (rd_idx_q <= lim))
		else $error("machine scan ran past the machine count");

	a_clear_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAX && rd_idx_q == lim) |=> (valid_q == '0))
		else $error("machine times not cleared after order close");

	a_makespan_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.sequence_done) |-> (res.makespan == '0))
		else $error("makespan given on a result that does not close the order");

	a_finish_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (new_time >= finish_q && new_time >= best_val_q))
		else $error("finish time wrapped instead of saturating");
`endif

endmodule

[rtl/flow_shop_makespan_evaluator_core.sv]
// Top level: configuration registers, stream ports and result register.
//
// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | tuser command, tdata job/stage/time_value, tlast last
// m_*     | out | m_tvalid/m_tready  | tdata job_finish/makespan, tlast sequence_done
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index register number, cfg_data value
//
// A schedule item looks up each stage in use, skips one whose time is zero, else scans
// its machines and writes the chosen one, and scans the last stage again when it closes
// the order; the one-entry-a-cycle read port of the machine free-time memory paces
// the scans. Reset clears all machine times and loads the register defaults; no clearing
// pass is needed. A stalled result waits in the output register while the next item
// is taken; the sequencer stalls only when a second result is due.
module flow_shop_makespan_evaluator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] job, [5:4] stage, [17:6] time_value, [23:18] zero
	input  logic [0:0]  s_tuser,   // [0] command
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [19:0] job_finish, [39:20] makespan
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	import fsme_pkg::*;

	logic [SCNT_W-1:0]            stages_q;
	logic [STAGES-1:0][MCNT_W-1:0] mach_q;
	logic [SCNT_W-1:0]            stages_eff;
	logic [MCNT_W-1:0]            mach_eff [STAGES];
	cfg_t                         cfg;
	item_t                        item;
	logic                         res_valid;
	logic                         res_ready;
	res_t                         res;
	logic                         out_valid_q;
	res_t                         out_res_q;

	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stages_q  <= SCNT_W'(2);
			mach_q[0] <= MCNT_W'(11);
			mach_q[1] <= MCNT_W'(5);
			mach_q[2] <= MCNT_W'(1);
			mach_q[3] <= MCNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STAGES: stages_q  <= cfg_data[SCNT_W-1:0];
				REG_MACH0:  mach_q[0] <= cfg_data;
				REG_MACH1:  mach_q[1] <= cfg_data;
				REG_MACH2:  mach_q[2] <= cfg_data;
				REG_MACH3:  mach_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Clamp counts into range and turn them into last indexes
	always_comb begin
		stages_eff = stages_q;
		if (stages_q == '0) begin
			stages_eff = SCNT_W'(1);
		end else if (32'(stages_q) > STAGES) begin
			stages_eff = SCNT_W'(STAGES);
		end
		cfg.last_stage = STG_W'(stages_eff - SCNT_W'(1));
		for (int i = 0; i < STAGES; i++) begin
			mach_eff[i] = mach_q[i];
			if (mach_q[i] == '0) begin
				mach_eff[i] = MCNT_W'(1);
			end else if (32'(mach_q[i]) > MACHINES) begin
				mach_eff[i] = MCNT_W'(MACHINES);
			end
			cfg.last_mach[i] = MCH_W'(mach_eff[i] - MCNT_W'(1));
		end
	end

	// Unpack the input transfer
	assign item.command    = s_tuser[0];
	assign item.job        = s_tdata[3:0];
	assign item.stage      = s_tdata[5:4];
	assign item.time_value = s_tdata[17:6];
	assign item.last       = s_tlast;

	fsme_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.item     (item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register: free when empty or being taken
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.makespan, out_res_q.job_finish};
	assign m_tlast  = out_res_q.sequence_done;

endmodule
